// ----- design/syard_pkg.sv -----
// Types, codes and helper functions for the shunting-yard converter.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package syard_pkg;

	localparam logic [2:0] TOK_NUMBER = 3'd0;
	localparam logic [2:0] TOK_OPEN   = 3'd1;
	localparam logic [2:0] TOK_CLOSE  = 3'd2;
	localparam logic [2:0] TOK_OPER   = 3'd3;
	localparam logic [2:0] TOK_END    = 3'd4;

	localparam logic [2:0] OP_ADD     = 3'd0;
	localparam logic [2:0] OP_SUB     = 3'd1;
	localparam logic [2:0] OP_PERCENT = 3'd2;
	localparam logic [2:0] OP_MUL     = 3'd3;
	localparam logic [2:0] OP_DIV     = 3'd4;
	localparam logic [2:0] OP_RECIP   = 3'd5;
	localparam logic [2:0] OP_POWER   = 3'd6;
	localparam logic [2:0] PAREN_MARK = 3'd7;

	localparam logic [1:0] OUT_NUMBER = 2'd0;
	localparam logic [1:0] OUT_OPER   = 2'd1;
	localparam logic [1:0] OUT_END    = 2'd2;
	localparam logic [1:0] OUT_ERROR  = 2'd3;

	localparam logic [1:0] ERR_NONE      = 2'd0;
	localparam logic [1:0] ERR_UNMATCHED = 2'd1;
	localparam logic [1:0] ERR_OVERFLOW  = 2'd2;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPW         = $clog2(QUEUE_DEPTH);
	localparam int QCW         = $clog2(QUEUE_DEPTH + 1);

	typedef struct packed {
		logic [2:0]  token_kind;
		logic [2:0]  operator_code;
		logic [63:0] number_bits;
	} tok_item_t;

	typedef struct packed {
		logic [1:0]  out_kind;
		logic [2:0]  out_operator;
		logic [63:0] out_number;
		logic [1:0]  error_code;
		logic        last_of_run;
	} res_item_t;

	typedef enum logic [2:0] {
		CMD_NUMBER,
		CMD_OPEN,
		CMD_CLOSE,
		CMD_OPER,
		CMD_END
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t   kind;
		logic [2:0]  op;
		logic [1:0]  prec;
		logic [63:0] number;
	} cmd_t;

	function automatic logic [1:0] prec_of(input logic [2:0] code);
		logic [1:0] p;
		case (code)
			OP_ADD, OP_SUB, OP_PERCENT: p = 2'd1;
			OP_MUL, OP_DIV:             p = 2'd2;
			OP_POWER:                   p = 2'd3;
			default:                    p = 2'd0;
		endcase
		return p;
	endfunction

endpackage

`default_nettype wire

// ----- design/shunting_yard_infix_to_postfix.sv -----
// Shunting-yard infix to postfix converter, top level.
// Depends on syard_pkg, syard_front, syard_queue and syard_back.
//
// Infix tokens enter on tok (tok_valid / tok_stall); postfix items leave on res
// (res_valid / res_stall). A request moves when valid is high and stall is low.
// Numbers pass through unchanged; operators and open parens wait on an operator
// stack of STACK_DEPTH entries. The last item caused by a token has last_of_run set.
// Unknown token kinds and operator codes are dropped with no result.
// With the engine idle, a token's first result passes through the command queue and
// the result register before it appears on res.
// The stack engine does one stack push or pop at a time. An operator first pops each
// stacked operator of equal or higher precedence and is then pushed; a close paren
// pops operators up to and including its open paren; end pops every stacked entry.
// A two-entry command queue decouples the token input from the engine; tok_stall
// rises only when that queue is full.
// A stalled result holds res and halts the engine; the queue then fills and stalls the
// input. Reset clears the queue, the stack count and the result valid flag; there is
// no clearing pass, so tokens are taken as soon as reset is released.
`timescale 1ns / 1ps
`default_nettype none

module shunting_yard_infix_to_postfix
	import syard_pkg::*;
#(
	parameter int STACK_DEPTH = 16
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      tok_valid,
	output logic           tok_stall,
	input  wire tok_item_t tok,
	output logic           res_valid,
	input  wire logic      res_stall,
	output res_item_t      res
);

	logic wr_valid;
	cmd_t wr_cmd;
	logic q_full;
	logic head_valid;
	cmd_t head;
	logic rd_pop;

	syard_front u_front (
		.tok_valid (tok_valid),
		.tok_stall (tok_stall),
		.tok       (tok),
		.wr_valid  (wr_valid),
		.wr_cmd    (wr_cmd),
		.q_full    (q_full)
	);

	syard_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.wr_valid   (wr_valid),
		.wr_cmd     (wr_cmd),
		.full       (q_full),
		.head_valid (head_valid),
		.head       (head),
		.rd_pop     (rd_pop)
	);

	syard_back #(
		.STACK_DEPTH (STACK_DEPTH)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.rd_pop     (rd_pop),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.res        (res)
	);

endmodule

`default_nettype wire

// ----- design/syard_front.sv -----
// Front end: accepts infix tokens, drops unknown ones and turns the rest into commands.
// Depends on syard_pkg; feeds syard_queue.
`timescale 1ns / 1ps
`default_nettype none

module syard_front
	import syard_pkg::*;
(
	input  wire logic      tok_valid,
	output logic           tok_stall,
	input  wire tok_item_t tok,
	output logic           wr_valid,
	output cmd_t           wr_cmd,
	input  wire logic      q_full
);

	logic known;

	always_comb begin
		known         = 1'b1;
		wr_cmd.kind   = CMD_NUMBER;
		wr_cmd.op     = tok.operator_code;
		wr_cmd.prec   = prec_of(tok.operator_code);
		wr_cmd.number = tok.number_bits;
		case (tok.token_kind)
			TOK_NUMBER: wr_cmd.kind = CMD_NUMBER;
			TOK_OPEN:   wr_cmd.kind = CMD_OPEN;
			TOK_CLOSE:  wr_cmd.kind = CMD_CLOSE;
			TOK_OPER: begin
				wr_cmd.kind = CMD_OPER;
				known       = tok.operator_code inside {[OP_ADD:OP_POWER]};
			end
			TOK_END:    wr_cmd.kind = CMD_END;
			default:    known = 1'b0;
		endcase
	end

	// hold the sender while the queue has no room
	assign tok_stall = q_full;
	assign wr_valid  = tok_valid && known && !q_full;

endmodule

`default_nettype wire

// ----- design/syard_queue.sv -----
// Short command queue between the token front end and the stack engine.
// Depends on syard_pkg.
`timescale 1ns / 1ps
`default_nettype none

module syard_queue
	import syard_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic wr_valid,
	input  wire cmd_t wr_cmd,
	output logic      full,
	output logic      head_valid,
	output cmd_t      head,
	input  wire logic rd_pop
);

	cmd_t             slot_q [QUEUE_DEPTH];
	logic [QPW-1:0]   wr_ptr_q;
	logic [QPW-1:0]   rd_ptr_q;
	logic [QCW-1:0]   cnt_q;
	logic             do_wr;
	logic             do_rd;

	assign full       = cnt_q == QCW'(QUEUE_DEPTH);
	assign head_valid = cnt_q != '0;
	assign head       = slot_q[rd_ptr_q];
	assign do_wr      = wr_valid && !full;
	assign do_rd      = rd_pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_wr) begin
			slot_q[wr_ptr_q] <= wr_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == QPW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + QPW'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == QPW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + QPW'(1);
			end
			case ({do_wr, do_rd})
				2'b10:   cnt_q <= cnt_q + QCW'(1);
				2'b01:   cnt_q <= cnt_q - QCW'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

`default_nettype wire

// ----- design/syard_back.sv -----
// Back end: runs queued commands against the operator stack, one push or pop a cycle
// unless res stalls, and drives the registered result channel. Depends on syard_pkg.
`timescale 1ns / 1ps
`default_nettype none

module syard_back
	import syard_pkg::*;
#(
	parameter int STACK_DEPTH = 16
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic head_valid,
	input  wire cmd_t head,
	output logic      rd_pop,
	output logic      res_valid,
	input  wire logic res_stall,
	output res_item_t res
);

	localparam int CW    = $clog2(STACK_DEPTH + 1);
	localparam int AW    = $clog2(STACK_DEPTH);
	localparam int MEM_N = 1 << AW;

	logic [2:0]    mem [MEM_N];
	logic [2:0]    top_q;
	logic [2:0]    rd_q;
	logic [CW-1:0] cnt_q;
	res_item_t     res_q;
	logic          res_valid_q;

	logic          out_free;
	logic          go;
	logic          emit;
	logic          push;
	logic          pop;
	logic          done;
	logic [2:0]    push_val;
	res_item_t     item;
	logic          has_top;
	logic          has_next;
	logic          full;
	logic [AW-1:0] wr_addr;
	logic [AW-1:0] rd_addr;

	assign out_free = !res_valid_q || !res_stall;
	assign go       = head_valid && out_free;
	assign has_top  = cnt_q != '0;
	assign has_next = cnt_q >= CW'(2);
	assign full     = cnt_q == CW'(STACK_DEPTH);
	assign wr_addr  = AW'(cnt_q - CW'(1));
	assign rd_addr  = AW'(cnt_q - CW'(3));

	always_comb begin
		emit     = 1'b0;
		push     = 1'b0;
		pop      = 1'b0;
		done     = 1'b0;
		push_val = PAREN_MARK;
		item     = '{out_kind: OUT_OPER, out_operator: top_q, out_number: '0,
			error_code: ERR_NONE, last_of_run: 1'b0};
		if (go) begin
			case (head.kind)
				CMD_NUMBER: begin
					emit = 1'b1;
					done = 1'b1;
					item = '{out_kind: OUT_NUMBER, out_operator: '0,
						out_number: head.number, error_code: ERR_NONE, last_of_run: 1'b1};
				end
				CMD_OPEN: begin
					done = 1'b1;
					if (full) begin
						emit = 1'b1;
						item = '{out_kind: OUT_ERROR, out_operator: '0, out_number: '0,
							error_code: ERR_OVERFLOW, last_of_run: 1'b1};
					end else begin
						push = 1'b1;
					end
				end
				CMD_CLOSE: begin
					if (!has_top) begin
						emit = 1'b1;
						done = 1'b1;
						item = '{out_kind: OUT_ERROR, out_operator: '0, out_number: '0,
							error_code: ERR_UNMATCHED, last_of_run: 1'b1};
					end else if (top_q == PAREN_MARK) begin
						pop  = 1'b1;
						done = 1'b1;
					end else begin
						emit = 1'b1;
						pop  = 1'b1;
						item.last_of_run = has_next && rd_q == PAREN_MARK;
					end
				end
				CMD_OPER: begin
					if (has_top && top_q != PAREN_MARK && prec_of(top_q) >= head.prec) begin
						emit = 1'b1;
						pop  = 1'b1;
						item.last_of_run = !(has_next && rd_q != PAREN_MARK &&
							prec_of(rd_q) >= head.prec);
					end else if (full) begin
						emit = 1'b1;
						done = 1'b1;
						item = '{out_kind: OUT_ERROR, out_operator: '0, out_number: '0,
							error_code: ERR_OVERFLOW, last_of_run: 1'b1};
					end else begin
						push     = 1'b1;
						push_val = head.op;
						done     = 1'b1;
					end
				end
				CMD_END: begin
					if (!has_top) begin
						emit = 1'b1;
						done = 1'b1;
						item = '{out_kind: OUT_END, out_operator: '0, out_number: '0,
							error_code: ERR_NONE, last_of_run: 1'b1};
					end else begin
						pop  = 1'b1;
						emit = top_q != PAREN_MARK;
					end
				end
				default: done = 1'b1;
			endcase
		end
	end

	assign rd_pop = done;

	// spill the old top below on push, refill it from the prefetched entry on pop
	always_ff @(posedge clk) begin
		if (push) begin
			top_q <= push_val;
			if (has_top) begin
				mem[wr_addr] <= top_q;
				rd_q         <= top_q;
			end
		end else if (pop) begin
			top_q <= rd_q;
			rd_q  <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (push) begin
			cnt_q <= cnt_q + CW'(1);
		end else if (pop) begin
			cnt_q <= cnt_q - CW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (out_free) begin
			res_valid_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && emit) begin
			res_q <= item;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

`ifndef SYNTH
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(STACK_DEPTH))
		else $error("stack count beyond depth");

	a_cnt_step: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && pop))
		else $error("push and pop in one cycle");

	a_err_code: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.out_kind == OUT_ERROR |-> res.error_code != ERR_NONE)
		else $error("error item without error code");

	a_end_last: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (res.out_kind == OUT_END || res.out_kind == OUT_ERROR)
		|-> res.last_of_run)
		else $error("end or error item not last of run");

	a_no_step_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |-> !emit)
		else $error("result produced while output stalled");
`endif

endmodule

`default_nettype wire
